>>> rtl/mpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Min priority queue package
// Shared widths, request and response types, and codes of the priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int unsigned ValueWidth    = 32;
  localparam int unsigned PriorityWidth = 8;
  localparam int unsigned CountWidth    = 5;
  localparam int unsigned DefaultDepth  = 16;

  typedef enum logic [1:0] {
    ActEnqueue = 2'd0,
    ActDequeue = 2'd1,
    ActSearch  = 2'd2,
    ActFront   = 2'd3
  } mpq_action_e;

  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatEmpty = 2'd1,
    StatFull  = 2'd2
  } mpq_status_e;

  typedef struct packed {
    mpq_action_e              action;
    logic [ValueWidth-1:0]    data_value;
    logic [PriorityWidth-1:0] item_priority;
  } mpq_in_t;

  typedef struct packed {
    logic [ValueWidth-1:0]    out_value;
    logic [PriorityWidth-1:0] out_priority;
    logic                     found;
    logic                     is_empty;
    logic [CountWidth-1:0]    entry_count;
    mpq_status_e              status;
  } mpq_out_t;

  typedef struct packed {
    logic [ValueWidth-1:0]    value;
    logic [PriorityWidth-1:0] prio;
    logic                     found;
    mpq_status_e              status;
  } mpq_res_t;

endpackage
`default_nettype wire

>>> rtl/mpq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> rtl/min_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Min priority queue
// Bounded queue kept in arrival order; dequeue returns the lowest priority
// number, oldest first among ties, using one sequential scan over the RAM.
// ----------------------------------------------------------------------------
// Enqueue writes one RAM entry unless the queue is full, and any request on an empty
// queue is answered without a RAM read; front reads the oldest entry; search reads
// every entry in turn; dequeue reads every entry in turn and then moves each entry
// behind the removed one up one place, all through the single RAM read port.
// One request is in work at a time; the next is taken once the response is registered.
// Reset clears the entry count and all control state but not the entry RAM.
module min_priority_queue #(
  parameter int unsigned DEPTH = mpq_pkg::DefaultDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire mpq_pkg::mpq_in_t in_req_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output mpq_pkg::mpq_out_t     out_rsp_o
);

  import mpq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = ValueWidth + PriorityWidth;

  typedef enum logic [2:0] {
    StIdle,
    StStart,
    StScan,
    StShift,
    StFront,
    StDone
  } state_e;

  state_e                   state_q, state_d;
  mpq_in_t                  req_q, req_d;
  logic [CW-1:0]            count_q, count_d;
  logic [AW-1:0]            idx_q, idx_d;
  logic [ValueWidth-1:0]    best_val_q, best_val_d;
  logic [PriorityWidth-1:0] best_pri_q, best_pri_d;
  logic                     hit_q, hit_d;
  mpq_res_t                 res_q, res_d;
  logic                     out_valid_q, out_valid_d;
  mpq_out_t                 out_q, out_d;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [EW-1:0]            ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [EW-1:0]            ram_rdata;

  logic [ValueWidth-1:0]    rd_val;
  logic [PriorityWidth-1:0] rd_pri;
  logic [CW-1:0]            idx_next;
  logic [CW-1:0]            idx_skip;
  logic [CW-1:0]            best_next;
  logic                     take;
  logic                     scan_last;
  logic                     out_free;

  mpq_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_val    = ram_rdata[EW-1:PriorityWidth];
  assign rd_pri    = ram_rdata[PriorityWidth-1:0];
  assign idx_next  = CW'(idx_q) + CW'(1);
  assign idx_skip  = CW'(idx_q) + CW'(2);
  assign scan_last = (idx_next == count_q);
  assign take      = (idx_q == '0) || (rd_pri < best_pri_q);
  assign out_free  = !out_valid_q || out_ready_i;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  logic [AW-1:0] best_idx_q, best_idx_d;
  logic [AW-1:0] fin_idx;

  assign fin_idx   = take ? idx_q : best_idx_q;
  assign best_next = CW'(fin_idx) + CW'(1);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    count_d     = count_q;
    idx_d       = idx_q;
    best_idx_d  = best_idx_q;
    best_val_d  = best_val_q;
    best_pri_d  = best_pri_q;
    hit_d       = hit_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = ram_rdata;
    ram_raddr   = '0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          req_d   = in_req_i;
          state_d = StStart;
        end
      end
      StStart: begin
        res_d = '{value: '0, prio: '0, found: 1'b0, status: StatOk};
        idx_d = '0;
        hit_d = 1'b0;
        unique case (req_q.action)
          ActEnqueue: begin
            if (count_q == CW'(DEPTH)) begin
              res_d.status = StatFull;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_q[AW-1:0];
              ram_wdata = {req_q.data_value, req_q.item_priority};
              count_d   = count_q + CW'(1);
            end
            state_d = StDone;
          end
          ActDequeue, ActFront: begin
            if (count_q == '0) begin
              res_d.status = StatEmpty;
              state_d      = StDone;
            end else begin
              state_d = (req_q.action == ActFront) ? StFront : StScan;
            end
          end
          ActSearch: begin
            state_d = (count_q == '0) ? StDone : StScan;
          end
          default: begin
            state_d = StDone;
          end
        endcase
      end
      StScan: begin
        if (req_q.action == ActSearch) begin
          if (rd_val == req_q.data_value) begin
            hit_d = 1'b1;
          end
        end else if (take) begin
          best_idx_d = idx_q;
          best_val_d = rd_val;
          best_pri_d = rd_pri;
        end
        if (!scan_last) begin
          ram_raddr = idx_next[AW-1:0];
          idx_d     = idx_next[AW-1:0];
        end else if (req_q.action == ActSearch) begin
          res_d.found = hit_d;
          state_d     = StDone;
        end else begin
          res_d.value = best_val_d;
          res_d.prio  = best_pri_d;
          if (best_next < count_q) begin
            ram_raddr = best_next[AW-1:0];
            idx_d     = fin_idx;
            state_d   = StShift;
          end else begin
            count_d = count_q - CW'(1);
            state_d = StDone;
          end
        end
      end
      StShift: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = ram_rdata;
        if (idx_skip < count_q) begin
          ram_raddr = idx_skip[AW-1:0];
          idx_d     = idx_next[AW-1:0];
        end else begin
          count_d = count_q - CW'(1);
          state_d = StDone;
        end
      end
      StFront: begin
        res_d.value = rd_val;
        res_d.prio  = rd_pri;
        state_d     = StDone;
      end
      StDone: begin
        if (out_free) begin
          out_d = '{
            out_value:    res_q.value,
            out_priority: res_q.prio,
            found:        res_q.found,
            is_empty:     (count_q == '0),
            entry_count:  CountWidth'(count_q),
            status:       res_q.status
          };
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    idx_q      <= idx_d;
    best_idx_q <= best_idx_d;
    best_val_q <= best_val_d;
    best_pri_q <= best_pri_d;
    hit_q      <= hit_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == StStart || state_q == StShift))
    else $error("RAM written outside enqueue or shift");

  a_enqueue_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StStart && req_q.action == ActEnqueue && count_q < CW'(DEPTH))
      |=> count_q == $past(count_q) + CW'(1))
    else $error("enqueue did not advance the count");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StDone)
    else $error("response raised outside the done state");
`endif

endmodule
`default_nettype wire
